// ===== src/vgd_pkg.sv =====
// Voxel grid downsample package: defaults, register width, and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none
package vgd_pkg;

  localparam int MAX_VOXELS_DEF = 64;
  localparam int MAX_POINTS_DEF = 65536;
  localparam int COORD_BITS_DEF = 24;

  localparam int          VS_W     = 23;
  localparam logic [22:0] VS_RESET = 23'd160;

  typedef struct packed {
    logic       load;      // take the input transaction
    logic       div_start;
    logic       div_cent;  // divide sums by count, else point by voxel size
    logic [1:0] div_axis;
    logic       scan_clr;
    logic       rd_idx;
    logic       rd_best;
    logic       idx_inc;
    logic       upd;
    logic       ins;
    logic       drop;
    logic       emit_init;
    logic       sel_step;
    logic       out_load;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic pts_full;
    logic idx_end;
    logic table_full;
    logic table_empty;
    logic key_hit;
    logic div_done;
    logic cloud_end;
    logic last_one;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== src/vgd_div.sv =====
// Iterative floored division, one quotient bit per cycle.
// Signed dividend, unsigned nonzero divisor. No dependencies.
`default_nettype none
module vgd_div #(
  parameter int DW = 41,
  parameter int VW = 23
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [DW-1:0] dividend,
  input  wire logic        [VW-1:0] divisor,
  output logic                      done,
  output logic signed [DW-1:0]      quotient
);
  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] q;
  logic [VW-1:0] r;
  logic [VW-1:0] b;
  logic          neg;
  logic [VW:0]   r_sh;
  logic          ge;
  logic [VW:0]   r_nx;

  always_comb begin
    r_sh = {r, q[DW-1]};
    ge   = r_sh >= {1'b0, b};
    r_nx = ge ? (r_sh - {1'b0, b}) : r_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DW-1];
      q   <= dividend[DW-1] ? -dividend : dividend;
      r   <= '0;
      b   <= divisor;
    end else if (busy) begin
      q <= {q[DW-2:0], ge};
      r <= r_nx[VW-1:0];
    end
  end

  // floor toward minus infinity: -(q+1) = ~q when a remainder is left
  assign quotient = !neg ? q : ((r != '0) ? ~q : -q);

endmodule
`default_nettype wire

// ===== src/vgd_dp.sv =====
// Voxel grid downsample datapath: voxel table memory, counters, selection
// registers and output register. Depends on vgd_pkg and vgd_div.
`default_nettype none
module vgd_dp #(
  parameter int MAX_VOXELS = 64,
  parameter int MAX_POINTS = 65536,
  parameter int COORD_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [vgd_pkg::VS_W-1:0]     cfg_wdata,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  input  wire logic signed [COORD_BITS-1:0] point_z,
  input  wire logic                         cloud_end,
  input  wire vgd_pkg::cmd_t                cmd,
  output vgd_pkg::stat_t                    st,
  output logic signed [COORD_BITS-1:0]      centroid_x,
  output logic signed [COORD_BITS-1:0]      centroid_y,
  output logic signed [COORD_BITS-1:0]      centroid_z,
  output logic                              final_voxel,
  output logic                              points_dropped,
  output logic                              out_valid,
  input  wire logic                         out_stall
);
  import vgd_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = COORD_BITS + CNT_W;
  localparam int IDX_W = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;
  localparam int UW    = $clog2(MAX_VOXELS + 1);
  localparam int DVS_W = (CNT_W > VS_W) ? CNT_W : VS_W;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] kx;
    logic signed [COORD_BITS-1:0] ky;
    logic signed [COORD_BITS-1:0] kz;
    logic signed [SUM_W-1:0]      sx;
    logic signed [SUM_W-1:0]      sy;
    logic signed [SUM_W-1:0]      sz;
    logic        [CNT_W-1:0]      cnt;
  } entry_t;

  entry_t mem [MAX_VOXELS];
  entry_t rdata;

  logic [VS_W-1:0]              vs;
  logic signed [COORD_BITS-1:0] px, py, pz;
  logic                         pend;
  logic signed [COORD_BITS-1:0] kx, ky, kz;
  logic signed [COORD_BITS-1:0] cx, cy, cz;
  logic signed [COORD_BITS-1:0] bx, by, bz;
  logic signed [COORD_BITS-1:0] lx, ly, lz;
  logic [IDX_W-1:0]             best_idx;
  logic                         have_best;
  logic                         have_last;
  logic [UW-1:0]                used;
  logic [UW-1:0]                idx;
  logic [UW-1:0]                emitted;
  logic [CNT_W-1:0]             taken;
  logic                         drop;

  logic signed [SUM_W-1:0] sx_p, sy_p, sz_p;
  logic signed [SUM_W-1:0] div_a;
  logic [DVS_W-1:0]        div_b;
  logic signed [SUM_W-1:0] div_q;
  logic                    div_done;
  logic                    above_last;
  logic                    below_best;
  logic [IDX_W-1:0]        rd_addr;

  function automatic logic key_lt(
    input logic signed [COORD_BITS-1:0] ax, ay, az, cx_, cy_, cz_
  );
    if (ax != cx_) return ax < cx_;
    if (ay != cy_) return ay < cy_;
    return az < cz_;
  endfunction

  assign sx_p = {{CNT_W{px[COORD_BITS-1]}}, px};
  assign sy_p = {{CNT_W{py[COORD_BITS-1]}}, py};
  assign sz_p = {{CNT_W{pz[COORD_BITS-1]}}, pz};

  always_comb begin
    unique case (cmd.div_axis)
      2'd0:    div_a = cmd.div_cent ? rdata.sx : sx_p;
      2'd1:    div_a = cmd.div_cent ? rdata.sy : sy_p;
      default: div_a = cmd.div_cent ? rdata.sz : sz_p;
    endcase
    if (cmd.div_cent)       div_b = DVS_W'(rdata.cnt);
    else if (vs == '0)      div_b = DVS_W'(1);
    else                    div_b = DVS_W'(vs);
  end

  vgd_div #(.DW(SUM_W), .VW(DVS_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign above_last = !have_last || key_lt(lx, ly, lz, rdata.kx, rdata.ky, rdata.kz);
  assign below_best = !have_best || key_lt(rdata.kx, rdata.ky, rdata.kz, bx, by, bz);
  assign rd_addr    = cmd.rd_best ? best_idx : idx[IDX_W-1:0];

  always_comb begin
    st.pts_full    = taken >= CNT_W'(MAX_POINTS);
    st.idx_end     = idx == used;
    st.table_full  = used == UW'(MAX_VOXELS);
    st.table_empty = used == '0;
    st.key_hit     = (rdata.kx == kx) && (rdata.ky == ky) && (rdata.kz == kz);
    st.div_done    = div_done;
    st.cloud_end   = pend;
    st.last_one    = (emitted + UW'(1)) == used;
    st.out_free    = !out_valid || !out_stall;
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      mem[idx[IDX_W-1:0]] <= '{kx: rdata.kx, ky: rdata.ky, kz: rdata.kz,
                               sx: rdata.sx + sx_p, sy: rdata.sy + sy_p,
                               sz: rdata.sz + sz_p, cnt: rdata.cnt + CNT_W'(1)};
    end else if (cmd.ins) begin
      mem[used[IDX_W-1:0]] <= '{kx: kx, ky: ky, kz: kz, sx: sx_p, sy: sy_p,
                                sz: sz_p, cnt: CNT_W'(1)};
    end
    if (cmd.rd_idx || cmd.rd_best) begin
      rdata <= mem[rd_addr];
    end
  end

  // control counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      vs        <= VS_RESET;
      used      <= '0;
      taken     <= '0;
      drop      <= 1'b0;
      have_best <= 1'b0;
      have_last <= 1'b0;
      emitted   <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) vs <= cfg_wdata;
      if (cmd.load) begin
        if (st.pts_full) drop <= 1'b1;
        else             taken <= taken + CNT_W'(1);
      end
      if (cmd.drop) drop <= 1'b1;
      if (cmd.ins)  used <= used + UW'(1);
      if (cmd.scan_clr) begin
        idx       <= '0;
        have_best <= 1'b0;
      end else if (cmd.idx_inc) begin
        idx <= idx + UW'(1);
      end
      if (cmd.sel_step && above_last && below_best) have_best <= 1'b1;
      if (cmd.emit_init) begin
        emitted   <= '0;
        have_last <= 1'b0;
      end else if (cmd.out_load) begin
        emitted   <= emitted + UW'(1);
        have_last <= 1'b1;
      end
      if (cmd.out_load)   out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cmd.clear) begin
        used  <= '0;
        taken <= '0;
        drop  <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px   <= point_x;
      py   <= point_y;
      pz   <= point_z;
      pend <= cloud_end;
    end
    if (div_done && !cmd.div_cent) begin
      unique case (cmd.div_axis)
        2'd0:    kx <= div_q[COORD_BITS-1:0];
        2'd1:    ky <= div_q[COORD_BITS-1:0];
        default: kz <= div_q[COORD_BITS-1:0];
      endcase
    end
    if (div_done && cmd.div_cent) begin
      unique case (cmd.div_axis)
        2'd0:    cx <= div_q[COORD_BITS-1:0];
        2'd1:    cy <= div_q[COORD_BITS-1:0];
        default: cz <= div_q[COORD_BITS-1:0];
      endcase
    end
    if (cmd.sel_step && above_last && below_best) begin
      bx       <= rdata.kx;
      by       <= rdata.ky;
      bz       <= rdata.kz;
      best_idx <= idx[IDX_W-1:0];
    end
    if (cmd.out_load) begin
      lx             <= bx;
      ly             <= by;
      lz             <= bz;
      centroid_x     <= cx;
      centroid_y     <= cy;
      centroid_z     <= cz;
      final_voxel    <= st.last_one;
      points_dropped <= drop;
    end
  end

endmodule
`default_nettype wire

// ===== src/vgd_ctrl.sv =====
// Voxel grid downsample controller: sequences divide, table search,
// insert and sorted emit. Depends on vgd_pkg.
`default_nettype none
module vgd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire vgd_pkg::stat_t st,
  output vgd_pkg::cmd_t       cmd
);
  import vgd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PDIV_GO, S_PDIV_WAIT, S_SRCH_RD, S_SRCH_CMP, S_INSERT,
    S_END_CHK, S_SEL_RD, S_SEL_CMP, S_FETCH, S_CDIV_GO, S_CDIV_WAIT, S_OUT
  } state_t;

  state_t     state;
  logic [1:0] axis;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd          = '0;
    cmd.div_axis = axis;
    unique case (state)
      S_IDLE:      cmd.load = in_valid;
      S_PDIV_GO:   cmd.div_start = 1'b1;
      S_PDIV_WAIT: cmd.scan_clr = st.div_done && (axis == 2'd2);
      S_SRCH_RD:   cmd.rd_idx = !st.idx_end;
      S_SRCH_CMP: begin
        cmd.upd     = st.key_hit;
        cmd.idx_inc = !st.key_hit;
      end
      S_INSERT: begin
        cmd.drop = st.table_full;
        cmd.ins  = !st.table_full;
      end
      S_END_CHK: begin
        cmd.clear     = st.cloud_end && st.table_empty;
        cmd.emit_init = st.cloud_end && !st.table_empty;
        cmd.scan_clr  = st.cloud_end && !st.table_empty;
      end
      S_SEL_RD:    cmd.rd_idx = !st.idx_end;
      S_SEL_CMP: begin
        cmd.sel_step = 1'b1;
        cmd.idx_inc  = 1'b1;
      end
      S_FETCH:     cmd.rd_best = 1'b1;
      S_CDIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_cent  = 1'b1;
      end
      S_CDIV_WAIT: cmd.div_cent = 1'b1;
      S_OUT: begin
        cmd.out_load = st.out_free;
        cmd.clear    = st.out_free && st.last_one;
        cmd.scan_clr = st.out_free && !st.last_one;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 2'd0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          axis  <= 2'd0;
          state <= st.pts_full ? S_END_CHK : S_PDIV_GO;
        end
        S_PDIV_GO: state <= S_PDIV_WAIT;
        S_PDIV_WAIT: if (st.div_done) begin
          axis  <= axis + 2'd1;
          state <= (axis == 2'd2) ? S_SRCH_RD : S_PDIV_GO;
        end
        S_SRCH_RD: state <= st.idx_end ? S_INSERT : S_SRCH_CMP;
        S_SRCH_CMP: state <= st.key_hit ? S_END_CHK : S_SRCH_RD;
        S_INSERT: state <= S_END_CHK;
        S_END_CHK: begin
          if (!st.cloud_end || st.table_empty) state <= S_IDLE;
          else                                 state <= S_SEL_RD;
        end
        S_SEL_RD: state <= st.idx_end ? S_FETCH : S_SEL_CMP;
        S_SEL_CMP: state <= S_SEL_RD;
        S_FETCH: begin
          axis  <= 2'd0;
          state <= S_CDIV_GO;
        end
        S_CDIV_GO: state <= S_CDIV_WAIT;
        S_CDIV_WAIT: if (st.div_done) begin
          axis  <= axis + 2'd1;
          state <= (axis == 2'd2) ? S_OUT : S_CDIV_GO;
        end
        S_OUT: if (st.out_free) begin
          state <= st.last_one ? S_IDLE : S_SEL_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/voxel_grid_downsample.sv =====
// Voxel grid downsample top level: controller plus datapath.
// Depends on vgd_pkg, vgd_ctrl, vgd_dp (and vgd_div below it).
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   input   | in_valid / in_stall  | point_x, point_y, point_z, cloud_end
//   output  | out_valid/out_stall  | centroid_x/y/z, final_voxel, points_dropped
//   config  | cfg_we               | cfg_wdata (voxel_size)
//
// Point time grows with E, the voxels in the table, and with SUM_W =
// COORD_BITS + clog2(MAX_POINTS+1): the shared one-bit-per-cycle divider
// and the table search, which reads and compares one entry at a time, set it.
// Each centroid then takes a min search over the table and a divide.
// Reset is synchronous; the table needs no clearing pass.
// A waiting final result does not stall the next point; others hold the emit.
`default_nettype none
module voxel_grid_downsample #(
  parameter int MAX_VOXELS = vgd_pkg::MAX_VOXELS_DEF,
  parameter int MAX_POINTS = vgd_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = vgd_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [vgd_pkg::VS_W-1:0]     cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  input  wire logic signed [COORD_BITS-1:0] point_z,
  input  wire logic                         cloud_end,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [COORD_BITS-1:0]      centroid_x,
  output logic signed [COORD_BITS-1:0]      centroid_y,
  output logic signed [COORD_BITS-1:0]      centroid_z,
  output logic                              final_voxel,
  output logic                              points_dropped
);
  import vgd_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequence each transaction
  vgd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // hold the table, divide, select, drive the result
  vgd_dp #(
    .MAX_VOXELS (MAX_VOXELS),
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .point_x        (point_x),
    .point_y        (point_y),
    .point_z        (point_z),
    .cloud_end      (cloud_end),
    .cmd            (cmd),
    .st             (st),
    .centroid_x     (centroid_x),
    .centroid_y     (centroid_y),
    .centroid_z     (centroid_z),
    .final_voxel    (final_voxel),
    .points_dropped (points_dropped),
    .out_valid      (out_valid),
    .out_stall      (out_stall)
  );

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result loaded over a pending result");

  // never grow a full table
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |-> !st.table_full)
    else $error("insert into full voxel table");

  // accumulate only into a matching entry
  a_upd_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> st.key_hit)
    else $error("accumulate without key match");

  // insert never coincides with accumulate
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ins && cmd.upd))
    else $error("two table writes in one cycle");

endmodule
`default_nettype wire

// ===== dv/voxel_grid_downsample_tb.sv =====
// Self-checking testbench for voxel_grid_downsample: streams point clouds with
// random idling on both channels and checks every centroid against an in-bench
// voxel table predictor. Depends on vgd_pkg and the voxel_grid_downsample RTL.
`timescale 1ns / 1ps
`default_nettype none
module voxel_grid_downsample_tb;
  import vgd_pkg::*;

  localparam int  CW         = 24;
  localparam int  N_VOX      = 64;
  localparam int  N_PTS      = 65536;
  localparam int  LIMIT      = 2000000;
  // Wait well past the longest point or centroid in the RTL before touching
  // the register.
  localparam int  SETTLE     = 400;
  localparam longint C_MAX   = 64'sd8388607;
  localparam longint C_MIN   = -64'sd8388608;

  typedef struct {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic                 last;
    logic                 dropped;
  } centroid_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [VS_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] point_x = '0;
  logic signed [CW-1:0] point_y = '0;
  logic signed [CW-1:0] point_z = '0;
  logic cloud_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] centroid_x;
  logic signed [CW-1:0] centroid_y;
  logic signed [CW-1:0] centroid_z;
  logic final_voxel;
  logic points_dropped;

  voxel_grid_downsample u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_z       (point_z),
    .cloud_end     (cloud_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .centroid_x    (centroid_x),
    .centroid_y    (centroid_y),
    .centroid_z    (centroid_z),
    .final_voxel   (final_voxel),
    .points_dropped(points_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a copy of the voxel table and the register.
  logic [VS_W-1:0] edge_len;
  longint vox_kx[N_VOX], vox_ky[N_VOX], vox_kz[N_VOX];
  longint vox_sx[N_VOX], vox_sy[N_VOX], vox_sz[N_VOX];
  longint vox_cnt[N_VOX];
  int     vox_used;
  int     cloud_pts;
  bit     cloud_drop;
  centroid_t centroid_q[$];

  int  errors = 0;
  int  points_sent = 0;
  int  centroids_seen = 0;
  int  clouds_sent = 0;
  int  drop_clouds = 0;
  int  cycles = 0;
  bit  idling_on = 1'b1;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic bit voxel_before(int a, int b);
    if (vox_kx[a] != vox_kx[b]) return vox_kx[a] < vox_kx[b];
    if (vox_ky[a] != vox_ky[b]) return vox_ky[a] < vox_ky[b];
    return vox_kz[a] < vox_kz[b];
  endfunction

  // Bin one point, and on the last point of a cloud queue its centroids in
  // ascending voxel order, then empty the table.
  task automatic bin_point(longint x, longint y, longint z, bit last);
    longint s, kx, ky, kz;
    int     ord[N_VOX];
    int     j, cur, hit;
    centroid_t c;
    s   = (edge_len == 0) ? 1 : longint'(edge_len);
    kx  = floor_quot(x, s);
    ky  = floor_quot(y, s);
    kz  = floor_quot(z, s);
    hit = -1;
    if (cloud_pts >= N_PTS) begin
      cloud_drop = 1'b1;
    end else begin
      cloud_pts++;
      for (int i = 0; i < vox_used; i++)
        if (hit < 0 && vox_kx[i] == kx && vox_ky[i] == ky && vox_kz[i] == kz) hit = i;
      if (hit >= 0) begin
        vox_sx[hit] += x;
        vox_sy[hit] += y;
        vox_sz[hit] += z;
        vox_cnt[hit]++;
      end else if (vox_used >= N_VOX) begin
        cloud_drop = 1'b1;
      end else begin
        vox_kx[vox_used]  = kx;
        vox_ky[vox_used]  = ky;
        vox_kz[vox_used]  = kz;
        vox_sx[vox_used]  = x;
        vox_sy[vox_used]  = y;
        vox_sz[vox_used]  = z;
        vox_cnt[vox_used] = 1;
        vox_used++;
      end
    end
    if (!last) return;
    for (int i = 0; i < vox_used; i++) begin
      cur = i;
      j   = i;
      while (j > 0 && voxel_before(cur, ord[j-1])) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = cur;
    end
    for (int i = 0; i < vox_used; i++) begin
      c.cx      = CW'(floor_quot(vox_sx[ord[i]], vox_cnt[ord[i]]));
      c.cy      = CW'(floor_quot(vox_sy[ord[i]], vox_cnt[ord[i]]));
      c.cz      = CW'(floor_quot(vox_sz[ord[i]], vox_cnt[ord[i]]));
      c.last    = (i + 1 == vox_used);
      c.dropped = cloud_drop;
      centroid_q = {centroid_q, c};
    end
    clouds_sent++;
    if (cloud_drop) drop_clouds++;
    vox_used   = 0;
    cloud_pts  = 0;
    cloud_drop = 1'b0;
  endtask

  function automatic int idle_gap();
    int r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Offer one point, hold it until the block takes it, then idle a while.
  // in_stall is sampled at the falling edge, so the rising edge after a low
  // sample is the accepting edge.
  task automatic send_point(longint x, longint y, longint z, bit last);
    bit taken;
    int gap;
    in_valid  <= 1'b1;
    point_x   <= x[CW-1:0];
    point_y   <= y[CW-1:0];
    point_z   <= z[CW-1:0];
    cloud_end <= last;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    points_sent++;
    bin_point(x, y, z, last);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (centroid_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_edge_len(logic [VS_W-1:0] v);
    go_idle();
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    edge_len = v;
  endtask

  function automatic longint rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return C_MAX;
    if (r == 1) return C_MIN;
    return longint'($signed($urandom_range(0, 32'hFFFFFF) << 8)) >>> 8;
  endfunction

  // Coordinate near a centre, so that several points share a voxel.
  function automatic longint near(longint ctr, int spread);
    longint v;
    v = ctr + $signed($urandom_range(0, 2 * spread)) - spread;
    if (v > C_MAX) v = C_MAX;
    if (v < C_MIN) v = C_MIN;
    return v;
  endfunction

  task automatic send_cloud(int n_pts, int spread);
    longint bx, by, bz;
    bx = rand_coord();
    by = rand_coord();
    bz = rand_coord();
    for (int i = 0; i < n_pts; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_point(rand_coord(), rand_coord(), rand_coord(), i == n_pts - 1);
      else
        send_point(near(bx, spread), near(by, spread), near(bz, spread), i == n_pts - 1);
    end
  endtask

  // Default voxel size, coordinate extremes, negatives straddling zero,
  // and a cloud of a single point.
  task automatic test_extremes();
    send_point(C_MAX, C_MAX, C_MAX, 1'b0);
    send_point(C_MIN, C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_MIN, 0, 1'b0);
    send_point(-1, -1, -1, 1'b0);
    send_point(-160, -161, -159, 1'b0);
    send_point(0, 159, 160, 1'b0);
    send_point(C_MAX - 1, C_MAX, C_MAX, 1'b0);
    send_point(-3, -2, -1, 1'b1);
    send_point(5, -5, 77, 1'b1);
    send_point(C_MIN, C_MAX, -1, 1'b1);
  endtask

  // Smallest, largest and zero voxel size (zero behaves as one).
  task automatic test_edge_lengths();
    write_edge_len(23'd1);
    send_point(-1, 0, 1, 1'b0);
    send_point(-1, 0, 1, 1'b0);
    send_point(C_MAX, C_MIN, 3, 1'b1);
    write_edge_len({VS_W{1'b1}});
    send_point(C_MAX, C_MAX, C_MAX, 1'b0);
    send_point(C_MIN, C_MIN, C_MIN, 1'b0);
    send_point(C_MIN + 1, -1, 0, 1'b0);
    send_point(0, 1, -2, 1'b1);
    write_edge_len(23'd0);
    send_point(7, -7, 0, 1'b0);
    send_point(7, -7, 0, 1'b0);
    send_point(-7, 7, 1, 1'b1);
  endtask

  // Overflow the table: open more voxels than it holds, end on a dropped point.
  task automatic test_table_full();
    write_edge_len(23'd1);
    for (int i = 0; i < N_VOX + 4; i++)
      send_point(longint'(i) - 32, -longint'(i), 3 * longint'(i), 1'b0);
    send_point(5, 5, 5, 1'b0);
    send_point(1000, 1000, 1000, 1'b1);
  endtask

  // Hold the output off for a long stretch while points keep coming, then
  // pause the sender until every centroid has drained.
  task automatic test_backpressure();
    write_edge_len(23'd16);
    hold_req++;
    send_cloud(6, 40);
    send_cloud(12, 40);
    send_cloud(5, 200);
    go_idle();
    drain();
  endtask

  task automatic test_random_clouds(int n_items);
    int sent0;
    sent0 = points_sent;
    while (points_sent - sent0 < n_items) begin
      if ($urandom_range(0, 5) == 0) begin
        go_idle();
        drain();
        case ($urandom_range(0, 3))
          0: write_edge_len(VS_W'($urandom_range(1, 64)));
          1: write_edge_len(VS_W'($urandom_range(1, 23'h7FFFFF)));
          2: write_edge_len(VS_W'($urandom_range(100, 5000)));
          default: write_edge_len(23'd160);
        endcase
        idling_on = $urandom_range(0, 3) != 0;
      end
      send_cloud($urandom_range(1, 14), $urandom_range(1, 2000));
    end
  endtask

  // Output stall: random short stalls, occasional bursts, and one long hold
  // each time a test asks for it.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 3000;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (idling_on && $urandom_range(0, 99) < 2) begin
      hold_left = $urandom_range(15, 80);
      out_stall <= 1'b1;
    end else begin
      out_stall <= idling_on && ($urandom_range(0, 99) < 30);
    end
  end

  // Compare each accepted centroid with the oldest prediction.
  always @(posedge clk) begin
    centroid_t exp_c;
    if (!rst && out_valid && !out_stall) begin
      centroids_seen++;
      if (centroid_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected centroid (%0d,%0d,%0d) at cycle %0d",
                   centroid_x, centroid_y, centroid_z, cycles);
      end else begin
        exp_c = centroid_q.pop_front();
        if (centroid_x !== exp_c.cx || centroid_y !== exp_c.cy ||
            centroid_z !== exp_c.cz || final_voxel !== exp_c.last ||
            points_dropped !== exp_c.dropped) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: cyc %0d exp (%0d,%0d,%0d) l%0b d%0b got (%0d,%0d,%0d) l%0b d%0b",
                     cycles, exp_c.cx, exp_c.cy, exp_c.cz, exp_c.last, exp_c.dropped,
                     centroid_x, centroid_y, centroid_z, final_voxel, points_dropped);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d centroids outstanding",
               cycles, centroid_q.size());
      $display("** voxel_grid_downsample: FAILED **");
      $finish;
    end
  end

  initial begin
    edge_len   = 23'd160;
    vox_used   = 0;
    cloud_pts  = 0;
    cloud_drop = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_edge_lengths();
    test_table_full();
    test_backpressure();
    test_random_clouds(140);
    go_idle();
    drain();
    repeat (SETTLE) @(posedge clk);
    if (centroid_q.size() != 0) errors++;
    $display("Covered %0d points in %0d clouds (%0d with drops), %0d centroids checked.",
             points_sent, clouds_sent, drop_clouds, centroids_seen);
    $display("Voxel sizes from 0 to max, coordinate extremes, table overflow, long output hold.");
    if (errors == 0) begin
      $display("** voxel_grid_downsample: PASSED **");
    end else begin
      $display("** voxel_grid_downsample: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
